// ===== hw/rtl/lbve_pkg.sv =====
// Shared types and constants of the legged body velocity estimator.
`timescale 1ns / 1ps
`default_nettype none
package lbve_pkg;
	localparam int NUM_LEGS_DEF  = 6;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SUM_W         = 40;
	localparam int POS_W         = 32;

	localparam logic [31:0] INV_PERIOD_RST = 32'd87381333;
	localparam logic [31:0] PERIOD_RST     = 32'd3221225;

	localparam logic [1:0] PHASE_STANCE = 2'd0;
	localparam logic [1:0] PHASE_SWING  = 2'd1;
	localparam logic [1:0] TICKS_TRACK  = 2'd2;
	localparam logic [7:0] MOVING_MAX   = 8'd255;

	localparam logic CFG_INV_PERIOD = 1'b0;
	localparam logic CFG_PERIOD     = 1'b1;

	typedef struct packed {
		logic [1:0]       phase;
		logic             en;
		logic [1:0]       ticks;
		logic [POS_W-1:0] px;
		logic [POS_W-1:0] py;
		logic [POS_W-1:0] pz;
	} leg_ent_t;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_LEG  = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_ACC  = 9'b000001000,
		ST_CHK  = 9'b000010000,
		ST_DIV  = 9'b000100000,
		ST_IMUL = 9'b001000000,
		ST_IADD = 9'b010000000,
		ST_OUT  = 9'b100000000
	} state_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lbve_div.sv =====
// Three-lane restoring divider, one quotient bit per lane and cycle.
`timescale 1ns / 1ps
`default_nettype none
module lbve_div (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [2:0][lbve_pkg::SUM_W-1:0]     dvd,
	input  wire logic [7:0]                          dvs,
	output logic                                     done,
	output logic [2:0][lbve_pkg::SUM_W-1:0]          quo
);
	localparam int CNT_W = $clog2(lbve_pkg::SUM_W + 1);

	logic [CNT_W-1:0]                   cnt_q;
	logic                               busy_q;
	logic [2:0][8:0]                    rem_q;
	logic [2:0][lbve_pkg::SUM_W-1:0]    q_q;
	logic [7:0]                         dvs_q;
	logic [2:0][8:0]                    rem_d;
	logic [2:0][lbve_pkg::SUM_W-1:0]    q_d;
	logic [2:0][8:0]                    sh;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = {rem_q[i][7:0], q_q[i][lbve_pkg::SUM_W-1]};
			if (sh[i] >= {1'b0, dvs_q}) begin
				rem_d[i] = sh[i] - {1'b0, dvs_q};
				q_d[i]   = {q_q[i][lbve_pkg::SUM_W-2:0], 1'b1};
			end else begin
				rem_d[i] = sh[i];
				q_d[i]   = {q_q[i][lbve_pkg::SUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(lbve_pkg::SUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (busy_q) begin
			q_q   <= q_d;
			rem_q <= rem_d;
		end
	end

	assign quo = q_q;
endmodule
`default_nettype wire

// ===== hw/rtl/legged_body_velocity_estimator.sv =====
// Top level of the legged body velocity estimator.
// Usage:
// - One leg item per handshake on s_axis; tlast marks the last leg of a control
//   tick. Leg state (phase, tracking flag, tick count, last foot position) sits
//   in a small synchronous RAM indexed by leg, read at acceptance, written back.
// - A non-last item passes ST_LEG and ST_CHK; a tracking leg adds ST_MUL and
//   ST_ACC for each of three axis multiplies on the one 32x32 multiplier.
// - A tlast item then adds the averaging step: a bit-serial divide of the
//   three velocity sums (skipped when no leg moved) and position integration
//   on the same multiplier, ST_IMUL and ST_IADD for each axis, then ST_OUT.
// - One result item per tick on m_axis: averaged velocity and body position.
//   It sits in an output register; a new tick's legs are taken while it waits.
//   Only when a second result is ready and the first is still not taken does
//   the block hold (s_axis_tready low) until m_axis_tready.
// - Reset clears the leg valid bits (entries read as zero), sums, body position;
//   registers return to defaults. The user must write register cfg_index via
//   cfg_we (0 reciprocal period, 1 period) only while idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module legged_body_velocity_estimator #(
	parameter int NUM_LEGS  = lbve_pkg::NUM_LEGS_DEF,
	parameter int FRAC_BITS = lbve_pkg::FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// leg_index[2:0], gait_phase[4:3], foot_x[36:5], foot_y[68:37],
	// foot_z[100:69], zero pad[103:101]
	input  wire logic [103:0] s_axis_tdata,
	input  wire logic         s_axis_tlast,   // tick_end
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// body_vel_x[31:0], body_vel_y[63:32], body_vel_z[95:64],
	// body_pos_x[127:96], body_pos_y[159:128], body_pos_z[191:160]
	output logic [191:0]      m_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_wdata
);
	localparam int LEG_W = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
	localparam int SW    = lbve_pkg::SUM_W;

	lbve_pkg::state_t state_q;

	logic [31:0] inv_q, per_q;

	// leg RAM
	lbve_pkg::leg_ent_t mem_q [NUM_LEGS];
	lbve_pkg::leg_ent_t rdata_s1;
	logic [NUM_LEGS-1:0] vld_q;
	logic               vld_s1;
	logic               mem_we;
	lbve_pkg::leg_ent_t mem_wdata;
	logic [LEG_W-1:0]   rd_addr;

	// captured item
	logic [LEG_W-1:0]  leg_q;
	logic              inrange_q;
	logic [1:0]        phase_q;
	logic [2:0][31:0]  foot_q;
	logic              last_q;

	logic [2:0][31:0]  mlo_q;
	logic [2:0]        mhi_q, neg_q;
	logic [1:0]        ax_q;
	logic [63:0]       prod_q;

	logic [2:0][SW-1:0] sum_q;
	logic [7:0]         moving_q;
	logic [2:0][31:0]   avg_q, body_q;
	logic               out_v_q;

	logic [2:0]          in_fld_rng;
	logic                div_start, div_done;
	logic [2:0][SW-1:0]  div_dvd, div_quo;

	// the entry is read at acceptance, so it is ready in ST_LEG
	assign rd_addr = (state_q == lbve_pkg::ST_IDLE) ? s_axis_tdata[LEG_W-1:0] : leg_q;

	// ---------------- leg update -----------------
	lbve_pkg::leg_ent_t ent;
	logic               en_n, von;
	logic [1:0]         ticks_n;
	logic [2:0][32:0]   diff;
	logic [2:0][32:0]   mag;

	always_comb begin
		ent = vld_s1 ? rdata_s1 : '0;
		en_n = ent.en;
		if (phase_q == lbve_pkg::PHASE_STANCE && ent.phase == lbve_pkg::PHASE_SWING)
			en_n = 1'b1;
		else if (phase_q == lbve_pkg::PHASE_SWING && ent.phase == lbve_pkg::PHASE_SWING)
			en_n = 1'b0;
		ticks_n = '0;
		if (en_n)
			ticks_n = (ent.ticks < lbve_pkg::TICKS_TRACK) ? ent.ticks + 2'd1 : ent.ticks;
		von = en_n && (ticks_n >= lbve_pkg::TICKS_TRACK);
		diff[0] = {foot_q[0][31], foot_q[0]} - {ent.px[31], ent.px};
		diff[1] = {foot_q[1][31], foot_q[1]} - {ent.py[31], ent.py};
		diff[2] = {foot_q[2][31], foot_q[2]} - {ent.pz[31], ent.pz};
		for (int i = 0; i < 3; i++)
			mag[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
		mem_wdata.phase = phase_q;
		mem_wdata.en    = en_n;
		mem_wdata.ticks = ticks_n;
		mem_wdata.px    = en_n ? foot_q[0] : '0;
		mem_wdata.py    = en_n ? foot_q[1] : '0;
		mem_wdata.pz    = en_n ? foot_q[2] : '0;
		mem_we = (state_q == lbve_pkg::ST_LEG) && inrange_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[leg_q] <= mem_wdata;
		rdata_s1 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (mem_we)
				vld_q[leg_q] <= 1'b1;
			vld_s1 <= vld_q[rd_addr];
		end
	end

	// ---------------- shared multiplier -----------------
	logic [31:0] mul_a, mul_b, amag;
	always_comb begin
		amag = avg_q[ax_q][31] ? (32'd0 - avg_q[ax_q]) : avg_q[ax_q];
		if (state_q == lbve_pkg::ST_IMUL) begin
			mul_a = amag;
			mul_b = per_q;
		end else begin
			mul_a = mlo_q[ax_q];
			mul_b = inv_q;
		end
	end

	// leg velocity from the product: round, clamp, negate, saturate; saturating add to the sum
	logic [65:0]      p66;
	logic [65:0]      r66;
	logic [32:0]      rc;
	logic signed [33:0] v34;
	logic [31:0]      vel;
	logic signed [SW:0] sum_n;
	logic [SW-1:0]    sum_sat;

	always_comb begin
		p66 = {2'b0, prod_q} + (mhi_q[ax_q] ? {2'b0, inv_q, 32'd0} : 66'd0)
			+ (66'd1 << (FRAC_BITS - 1));
		r66 = p66 >> FRAC_BITS;
		rc  = (r66 > 66'h8000_0000) ? 33'h1_0000_0000 >> 1 : r66[32:0];
		v34 = neg_q[ax_q] ? signed'({1'b0, rc}) : -signed'({1'b0, rc});
		if (v34 > 34'sh0_7FFF_FFFF)
			vel = 32'h7FFF_FFFF;
		else
			vel = v34[31:0];
		sum_n = signed'({sum_q[ax_q][SW-1], sum_q[ax_q]}) + signed'((SW+1)'(signed'(vel)));
		if (sum_n[SW] != sum_n[SW-1])
			sum_sat = sum_n[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		else
			sum_sat = sum_n[SW-1:0];
	end

	// position step from the product, added to the body position with saturation
	logic [64:0]        ip;
	logic signed [33:0] step;
	logic signed [34:0] pos_n;
	logic [31:0]        pos_sat;
	always_comb begin
		ip   = {1'b0, prod_q} + 65'h0_8000_0000;
		step = avg_q[ax_q][31] ? -signed'({1'b0, ip[64:32]}) : signed'({1'b0, ip[64:32]});
		pos_n = signed'(35'(signed'(body_q[ax_q]))) + 35'(step);
		if (pos_n > 35'sh0_7FFF_FFFF)
			pos_sat = 32'h7FFF_FFFF;
		else if (pos_n < -35'sh0_8000_0000)
			pos_sat = 32'h8000_0000;
		else
			pos_sat = pos_n[31:0];
	end

	// averages from the divider
	logic [2:0][31:0] avg_n;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_dvd[i] = sum_q[i][SW-1] ? ('0 - sum_q[i]) : sum_q[i];
			if (sum_q[i][SW-1])
				avg_n[i] = (div_quo[i] > SW'(33'h0_8000_0000)) ? 32'h8000_0000
					: 32'd0 - div_quo[i][31:0];
			else
				avg_n[i] = (div_quo[i] > SW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
					: div_quo[i][31:0];
		end
	end

	assign div_start = (state_q == lbve_pkg::ST_CHK) && last_q && (moving_q != '0);

	lbve_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (moving_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign s_axis_tready = (state_q == lbve_pkg::ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign in_fld_rng    = s_axis_tdata[2:0];

	// ---------------- sequencer -----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lbve_pkg::ST_IDLE;
			inv_q    <= lbve_pkg::INV_PERIOD_RST;
			per_q    <= lbve_pkg::PERIOD_RST;
			sum_q    <= '0;
			moving_q <= '0;
			body_q   <= '0;
			avg_q    <= '0;
			out_v_q  <= 1'b0;
			ax_q     <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == lbve_pkg::CFG_INV_PERIOD)
					inv_q <= cfg_wdata;
				else
					per_q <= cfg_wdata;
			end
			// result register: loaded from ST_OUT, dropped once taken
			if (state_q == lbve_pkg::ST_OUT && (!out_v_q || m_axis_tready))
				out_v_q <= 1'b1;
			else if (m_axis_tready)
				out_v_q <= 1'b0;
			unique case (state_q)
				lbve_pkg::ST_IDLE: begin
					if (s_axis_tvalid)
						state_q <= lbve_pkg::ST_LEG;
				end
				lbve_pkg::ST_LEG: begin
					ax_q <= '0;
					if (inrange_q && von)
						state_q <= lbve_pkg::ST_MUL;
					else
						state_q <= lbve_pkg::ST_CHK;
				end
				lbve_pkg::ST_MUL: state_q <= lbve_pkg::ST_ACC;
				lbve_pkg::ST_ACC: begin
					sum_q[ax_q] <= sum_sat;
					if (ax_q == 2'd0 && vel != '0 && moving_q != lbve_pkg::MOVING_MAX)
						moving_q <= moving_q + 8'd1;
					if (ax_q == 2'd2) begin
						state_q <= lbve_pkg::ST_CHK;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= lbve_pkg::ST_MUL;
					end
				end
				lbve_pkg::ST_CHK: begin
					ax_q <= '0;
					if (!last_q)
						state_q <= lbve_pkg::ST_IDLE;
					else if (moving_q != '0)
						state_q <= lbve_pkg::ST_DIV;
					else begin
						avg_q   <= '0;
						state_q <= lbve_pkg::ST_IMUL;
					end
				end
				lbve_pkg::ST_DIV: begin
					if (div_done) begin
						avg_q   <= avg_n;
						state_q <= lbve_pkg::ST_IMUL;
					end
				end
				lbve_pkg::ST_IMUL: state_q <= lbve_pkg::ST_IADD;
				lbve_pkg::ST_IADD: begin
					body_q[ax_q] <= pos_sat;
					if (ax_q == 2'd2)
						state_q <= lbve_pkg::ST_OUT;
					else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= lbve_pkg::ST_IMUL;
					end
				end
				lbve_pkg::ST_OUT: begin
					if (!out_v_q || m_axis_tready) begin
						sum_q    <= '0;
						moving_q <= '0;
						state_q  <= lbve_pkg::ST_IDLE;
					end
				end
				default: state_q <= lbve_pkg::ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			leg_q     <= s_axis_tdata[LEG_W-1:0];
			inrange_q <= ({1'b0, in_fld_rng} < 4'(NUM_LEGS));
			phase_q   <= s_axis_tdata[4:3];
			foot_q[0] <= s_axis_tdata[36:5];
			foot_q[1] <= s_axis_tdata[68:37];
			foot_q[2] <= s_axis_tdata[100:69];
			last_q    <= s_axis_tlast;
		end
		if (state_q == lbve_pkg::ST_LEG) begin
			for (int i = 0; i < 3; i++) begin
				mlo_q[i] <= mag[i][31:0];
				mhi_q[i] <= mag[i][32];
				neg_q[i] <= diff[i][32];
			end
		end
		if (state_q == lbve_pkg::ST_MUL || state_q == lbve_pkg::ST_IMUL)
			prod_q <= mul_a * mul_b;
		if (state_q == lbve_pkg::ST_OUT && (!out_v_q || m_axis_tready))
			m_axis_tdata <= {body_q[2], body_q[1], body_q[0], avg_q[2], avg_q[1], avg_q[0]};
	end
endmodule
`default_nettype wire

// ===== hw/rtl/lbve_checker.sv =====
// Port-level checks of the estimator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lbve_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [191:0] m_axis_tdata,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready
);
	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	// a result is loaded only from the closing step, never while idle
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared without a tick being closed");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");
endmodule

bind legged_body_velocity_estimator lbve_checker u_lbve_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
`default_nettype wire

// ===== tb/sv/tb_legged_body_velocity_estimator.sv =====
// Self-checking testbench for the legged body velocity estimator.
`timescale 1ns / 1ps
`default_nettype none
module tb_legged_body_velocity_estimator;
	localparam int LEGS = 6;
	localparam int WATCHDOG_LIMIT = 20000;

	// first member sits in the top bits, so body_vel_x comes last
	typedef struct packed {
		logic signed [31:0] pz, py, px, vz, vy, vx;
	} body_est_t;

	logic         clk;
	logic         arst_n;
	logic [103:0] s_axis_tdata;
	logic         s_axis_tlast;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] m_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_wdata;

	legged_body_velocity_estimator dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [31:0]        inv_period, period;
	logic [1:0]         leg_phase [LEGS];
	logic               leg_track [LEGS];
	logic [1:0]         leg_ticks [LEGS];
	logic signed [63:0] leg_px [LEGS], leg_py [LEGS], leg_pz [LEGS];
	logic signed [63:0] sum_x, sum_y, sum_z;
	logic [7:0]         moving;
	logic signed [63:0] pos_x, pos_y, pos_z;

	body_est_t expected_est [$];
	bit  failed = 1'b0;
	bit  quiet;       // no idling in the last part
	int  idle_cycles = 0;
	int  out_stall = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [63:0] sat32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic signed [63:0] sat40(logic signed [63:0] v);
		if (v > 64'sd549755813887) return 64'sd549755813887;
		if (v < -64'sd549755813888) return -64'sd549755813888;
		return v;
	endfunction

	function automatic logic signed [63:0] foot_speed(logic signed [63:0] foot,
			logic signed [63:0] prev);
		logic signed [63:0] diff;
		logic [63:0]        mag, r;
		diff = foot - prev;
		mag = (diff < 0) ? -diff : diff;
		r = (mag * {32'd0, inv_period} + 64'd32768) >> 16;
		if (r > 64'h8000_0000) r = 64'h8000_0000;
		return sat32((diff < 0) ? $signed(r) : -$signed(r));
	endfunction

	function automatic logic signed [63:0] step_pos(logic signed [63:0] pos,
			logic signed [63:0] vel);
		logic [63:0] mag, r;
		mag = (vel < 0) ? -vel : vel;
		r = (mag * {32'd0, period} + 64'h8000_0000) >> 32;
		return sat32(pos + ((vel < 0) ? -$signed(r) : $signed(r)));
	endfunction

	function automatic logic signed [63:0] avg_of(logic signed [63:0] s);
		if (moving == 0) return 0;
		return sat32(s / $signed({56'd0, moving}));
	endfunction

	task automatic reset_model();
		inv_period = lbve_pkg::INV_PERIOD_RST;
		period = lbve_pkg::PERIOD_RST;
		for (int i = 0; i < LEGS; i++) begin
			leg_phase[i] = 0; leg_track[i] = 0; leg_ticks[i] = 0;
			leg_px[i] = 0; leg_py[i] = 0; leg_pz[i] = 0;
		end
		sum_x = 0; sum_y = 0; sum_z = 0; moving = 0;
		pos_x = 0; pos_y = 0; pos_z = 0;
	endtask

	task automatic predict_leg(logic [2:0] leg, logic [1:0] ph, logic [31:0] fx,
			logic [31:0] fy, logic [31:0] fz, logic last);
		logic signed [63:0] vx, vy, vz;
		body_est_t e;
		vx = 0; vy = 0; vz = 0;
		if (leg < LEGS) begin
			if (ph == lbve_pkg::PHASE_STANCE && leg_phase[leg] == lbve_pkg::PHASE_SWING)
				leg_track[leg] = 1;
			else if (ph == lbve_pkg::PHASE_SWING && leg_phase[leg] == lbve_pkg::PHASE_SWING)
				leg_track[leg] = 0;
			if (leg_track[leg]) begin
				if (leg_ticks[leg] < lbve_pkg::TICKS_TRACK) leg_ticks[leg]++;
				if (leg_ticks[leg] >= lbve_pkg::TICKS_TRACK) begin
					vx = foot_speed($signed(fx), leg_px[leg]);
					vy = foot_speed($signed(fy), leg_py[leg]);
					vz = foot_speed($signed(fz), leg_pz[leg]);
				end
				leg_px[leg] = $signed(fx); leg_py[leg] = $signed(fy); leg_pz[leg] = $signed(fz);
			end else begin
				leg_ticks[leg] = 0;
				leg_px[leg] = 0; leg_py[leg] = 0; leg_pz[leg] = 0;
			end
			leg_phase[leg] = ph;
			sum_x = sat40(sum_x + vx); sum_y = sat40(sum_y + vy); sum_z = sat40(sum_z + vz);
			if (vx != 0 && moving < lbve_pkg::MOVING_MAX) moving++;
		end
		if (last) begin
			vx = avg_of(sum_x); vy = avg_of(sum_y); vz = avg_of(sum_z);
			pos_x = step_pos(pos_x, vx); pos_y = step_pos(pos_y, vy);
			pos_z = step_pos(pos_z, vz);
			e.vx = vx[31:0]; e.vy = vy[31:0]; e.vz = vz[31:0];
			e.px = pos_x[31:0]; e.py = pos_y[31:0]; e.pz = pos_z[31:0];
			expected_est.push_back(e);
			sum_x = 0; sum_y = 0; sum_z = 0; moving = 0;
		end
	endtask

	// send one leg item; the predictor runs at acceptance. tvalid stays up
	// until the next item or an idle burst replaces it.
	task automatic send_leg(logic [2:0] leg, logic [1:0] ph, logic [31:0] fx,
			logic [31:0] fy, logic [31:0] fz, logic last);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tdata <= {3'd0, fz, fy, fx, ph, leg};
		s_axis_tlast <= last;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_leg(leg, ph, fx, fy, fz, last);
	endtask

	// wait for all results plus the block's drain time
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_est.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == lbve_pkg::CFG_INV_PERIOD) inv_period = val; else period = val;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_foot(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			default: return $signed($urandom_range(0, 40000)) - 20000;
		endcase
	endfunction

	// one full tick with a realistic gait: legs alternate swing/stance
	task automatic gait_tick(int t, int mode);
		logic [1:0] ph;
		for (int l = 0; l < LEGS; l++) begin
			ph = (((t / 3) + l) % 2 == 0) ? lbve_pkg::PHASE_STANCE : lbve_pkg::PHASE_SWING;
			send_leg(l[2:0], ph, rand_foot(mode), rand_foot(mode), rand_foot(mode),
				l == LEGS - 1);
		end
	endtask

	task automatic test_directed();
		// reach tracking on leg 0 with extreme deltas in both directions
		send_leg(3'd0, lbve_pkg::PHASE_SWING, 0, 0, 0, 1'b0);
		send_leg(3'd0, lbve_pkg::PHASE_STANCE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b0);
		send_leg(3'd0, lbve_pkg::PHASE_STANCE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h10000, 1'b1);
		send_leg(3'd0, lbve_pkg::PHASE_STANCE, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
			1'b1);
		// swing after swing clears tracking
		send_leg(3'd0, lbve_pkg::PHASE_SWING, 5, 5, 5, 1'b0);
		send_leg(3'd0, lbve_pkg::PHASE_SWING, 9, 9, 9, 1'b1);
		// phase not yet scheduled and phase code three
		send_leg(3'd1, 2'd2, 1, 2, 3, 1'b0);
		send_leg(3'd1, 2'd3, 4, 5, 6, 1'b1);
		// leg index out of range, with and without tick end
		send_leg(3'd6, lbve_pkg::PHASE_SWING, 1, 1, 1, 1'b0);
		send_leg(3'd7, lbve_pkg::PHASE_STANCE, 1, 1, 1, 1'b1);
		// repeated leg within a tick, then a tick with no moving legs
		send_leg(3'd2, lbve_pkg::PHASE_SWING, 0, 0, 0, 1'b0);
		send_leg(3'd2, lbve_pkg::PHASE_STANCE, 100, 0, 0, 1'b0);
		send_leg(3'd2, lbve_pkg::PHASE_STANCE, 200, 7, -7, 1'b0);
		send_leg(3'd2, lbve_pkg::PHASE_STANCE, 300, 9, -9, 1'b1);
		send_leg(3'd4, lbve_pkg::PHASE_STANCE, 0, 0, 0, 1'b1);
		drain();
	endtask

	task automatic test_registers();
		logic [31:0] inv_set [4] = '{32'hFFFF_FFFF, 32'd0, 32'd65536, 32'd87381333};
		logic [31:0] per_set [4] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd3221225};
		for (int k = 0; k < 4; k++) begin
			write_reg(lbve_pkg::CFG_INV_PERIOD, inv_set[k]);
			write_reg(lbve_pkg::CFG_PERIOD, per_set[k]);
			for (int t = 0; t < 12; t++) gait_tick(t, (k + t) % 4);
			drain();
		end
	endtask

	task automatic test_random();
		logic [2:0] leg;
		logic [1:0] ph;
		for (int n = 0; n < 1600; n++) begin
			if (n == 1400) quiet = 1;
			if ($urandom_range(0, 9) < 7) begin
				gait_tick(n, $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : 3);
				n += LEGS - 1;
			end else begin
				leg = 3'($urandom_range(0, 7));
				ph = 2'($urandom_range(0, 3));
				send_leg(leg, ph, rand_foot($urandom_range(0, 3)), $urandom(),
					$urandom(), $urandom_range(0, 3) == 0);
			end
		end
		send_leg(3'd0, lbve_pkg::PHASE_SWING, 0, 0, 0, 1'b1);
		drain();
	endtask

	// output ready: random stall bursts until the quiet part
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_stall <= 0;
		end else if (out_stall > 0) begin
			m_axis_tready <= 1'b0;
			out_stall <= out_stall - 1;
		end else if (!quiet && m_axis_tready && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			out_stall <= $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// check each accepted result against the oldest expectation
	always @(posedge clk) begin
		body_est_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_est.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				failed = 1;
			end else begin
				want = expected_est.pop_front();
				if (got.vx !== want.vx) $display("%0t: vel_x exp %h got %h", $time, want.vx, got.vx);
				if (got.vy !== want.vy) $display("%0t: vel_y exp %h got %h", $time, want.vy, got.vy);
				if (got.vz !== want.vz) $display("%0t: vel_z exp %h got %h", $time, want.vz, got.vz);
				if (got.px !== want.px) $display("%0t: pos_x exp %h got %h", $time, want.px, got.px);
				if (got.py !== want.py) $display("%0t: pos_y exp %h got %h", $time, want.py, got.py);
				if (got.pz !== want.pz) $display("%0t: pos_z exp %h got %h", $time, want.pz, got.pz);
				if (got !== want) failed = 1;
			end
		end
	end

	// watchdog: cycles with no handshake on either side and no register write
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("legged_body_velocity_estimator: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tdata = '0; s_axis_tlast = 1'b0; s_axis_tvalid = 1'b0;
		cfg_we = 1'b0; cfg_index = 1'b0; cfg_wdata = '0;
		quiet = 0;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_random();
		if (!failed && expected_est.size() == 0) begin
			$display("legged_body_velocity_estimator: match");
		end else begin
			$display("legged_body_velocity_estimator: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/lbve_pkg.sv
hw/rtl/lbve_div.sv
hw/rtl/legged_body_velocity_estimator.sv
hw/rtl/lbve_checker.sv
tb/sv/tb_legged_body_velocity_estimator.sv
